@@ rtl/nearest_point_search_defines.svh @@
// Assertion macros used by the checker file of the nearest point search.
// No dependencies; include by bare file name.
`ifndef NEAREST_POINT_SEARCH_DEFINES_SVH
`define NEAREST_POINT_SEARCH_DEFINES_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define NPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define NPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/nps_pkg.sv @@
// Shared types and constants for the nearest point search block.
// No dependencies.
package nps_pkg;

  // Default sizes of the point tables and coordinates.
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int COORD_BITS_DEF  = 16;

  // Fixed field widths of the stream payloads.
  localparam int ID_W      = 16;
  localparam int POS_W     = 16;
  localparam int IN_DATA_W = 64;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 24;

  // Command codes carried in the low bit of in_tuser.
  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_QUERY    = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_AX0,
    S_AX1,
    S_AX2,
    S_CMP,
    S_DONE
  } state_t;

  // Coordinate axis fed into the shared squaring unit.
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

endpackage

@@ rtl/nps_sq_unit.sv @@
// Shared squared-difference unit: registers (a - b)^2 for one axis per cycle.
// Depends on nps_pkg.
module nps_sq_unit import nps_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic signed [COORD_BITS-1:0] a,
  input  logic signed [COORD_BITS-1:0] b,
  output logic [2*COORD_BITS+1:0]   sq_r
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS + 2;

  logic signed [DIFF_W-1:0] diff;
  logic        [DIFF_W-1:0] mag;
  logic        [SQ_W-1:0]   sq_nxt;

  // Exact difference and its magnitude; the magnitude fits unsigned in DIFF_W bits.
  always_comb begin
    diff   = DIFF_W'(a) - DIFF_W'(b);
    mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    sq_nxt = SQ_W'(mag * mag);
  end

  // The product is registered before anyone uses it.
  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

endmodule

@@ rtl/nearest_point_search.sv @@
// Register: the result passes through the DONE state into the output register; the input is busy until then.
// Query over a group of n points: states AX0, AX1, AX2 and CMP per point, then DONE (DONE at once if empty).
// For each stored point one squaring unit serves x, y and z, then a compare.
// The input accepts no new item until the result is placed in the output register.
// Reset clears both point counts and the output valid; table contents need no clearing.
module nearest_point_search import nps_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entity_id[15:0], pos_x[31:16], pos_y[47:32], pos_z[63:48]
  input  logic [IN_USER_W-1:0]  in_tuser,   // cmd[0], owner[1]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // found[0], closest_id[16:1], table_full[17], zero[23:18]
);

  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int ENTRY_W   = ID_W + 3 * COORD_BITS;
  localparam int DIST_W    = 2 * COORD_BITS + 2;

  // Input field unpacking.
  logic                  in_cmd;
  logic                  in_owner;
  logic [ID_W-1:0]       in_id;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  logic [COORD_BITS-1:0] in_z;

  assign in_cmd   = in_tuser[0];
  assign in_owner = in_tuser[1];
  assign in_id    = in_tdata[ID_W-1:0];

  // Coordinates are the low COORD_BITS bits of each field, taken as signed; wider coordinates
  // see the whole 16-bit field as a positive value.
  generate
    if (COORD_BITS <= POS_W) begin : g_coord_narrow
      assign in_x = in_tdata[ID_W +: COORD_BITS];
      assign in_y = in_tdata[ID_W + POS_W +: COORD_BITS];
      assign in_z = in_tdata[ID_W + 2 * POS_W +: COORD_BITS];
    end else begin : g_coord_wide
      assign in_x = {{(COORD_BITS - POS_W){1'b0}}, in_tdata[ID_W +: POS_W]};
      assign in_y = {{(COORD_BITS - POS_W){1'b0}}, in_tdata[ID_W + POS_W +: POS_W]};
      assign in_z = {{(COORD_BITS - POS_W){1'b0}}, in_tdata[ID_W + 2 * POS_W +: POS_W]};
    end
  endgenerate

  // Registers.
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    player_cnt_r, enemy_cnt_r;
  logic [IDX_W-1:0]    idx_r;
  logic                q_owner_r;
  logic [COORD_BITS-1:0] q_x_r, q_y_r, q_z_r;
  logic [ENTRY_W-1:0]  rd_r;
  logic [DIST_W-1:0]   acc_r;
  logic [DIST_W-1:0]   best_r;
  logic                res_found_r;
  logic [ID_W-1:0]     res_id_r;
  logic                res_full_r;
  logic                out_valid_r;
  logic                out_found_r;
  logic [ID_W-1:0]     out_id_r;
  logic                out_full_r;

  // Point memory: player group in the lower half, enemy group in the upper half.
  logic [ENTRY_W-1:0]  mem [0:MEM_DEPTH-1];

  // Control from the sequencer.
  logic                accept;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic                load_out;
  axis_t               axis;

  // Datapath helpers.
  logic [CNT_W-1:0]    in_cnt;
  logic                in_full;
  logic [CNT_W-1:0]    q_cnt;
  logic                last_entry;
  logic [DIST_W-1:0]   cand_dist;
  logic                better;
  logic [DIST_W-1:0]   sq_r;
  logic [COORD_BITS-1:0] sq_a, sq_b;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_cnt    = in_owner ? enemy_cnt_r : player_cnt_r;
  assign in_full   = (in_cnt == CNT_W'(TABLE_DEPTH));
  assign q_cnt     = q_owner_r ? enemy_cnt_r : player_cnt_r;
  assign last_entry = (CNT_W'(idx_r) == q_cnt - CNT_W'(1));
  assign cand_dist = acc_r + sq_r;
  assign better    = (idx_r == '0) || (cand_dist < best_r);

  // Sequencer: next state and per-cycle controls.
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = {q_owner_r, idx_r + IDX_W'(1)};
    wr_en     = 1'b0;
    wr_addr   = {in_owner, in_cnt[IDX_W-1:0]};
    load_out  = 1'b0;
    axis      = AXIS_X;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_QUERY) begin
            rd_en   = 1'b1;
            rd_addr = {in_owner, IDX_W'(0)};
            state_nxt = (in_cnt == '0) ? S_DONE : S_AX0;
          end else begin
            wr_en     = !in_full;
            state_nxt = S_DONE;
          end
        end
      end
      S_AX0: begin
        axis      = AXIS_X;
        state_nxt = S_AX1;
      end
      S_AX1: begin
        axis      = AXIS_Y;
        state_nxt = S_AX2;
      end
      S_AX2: begin
        axis      = AXIS_Z;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // Fetch the next entry once the current one has been compared.
        rd_en     = !last_entry;
        state_nxt = last_entry ? S_DONE : S_AX0;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Point memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_z, in_y, in_x, in_id};
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Group fill counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_cnt_r <= '0;
      enemy_cnt_r  <= '0;
    end else if (wr_en) begin
      if (in_owner) begin
        enemy_cnt_r <= enemy_cnt_r + CNT_W'(1);
      end else begin
        player_cnt_r <= player_cnt_r + CNT_W'(1);
      end
    end
  end

  // Shared squaring unit, fed one axis per cycle.
  always_comb begin
    case (axis)
      AXIS_Y: begin
        sq_a = rd_r[ID_W + COORD_BITS +: COORD_BITS];
        sq_b = q_y_r;
      end
      AXIS_Z: begin
        sq_a = rd_r[ID_W + 2 * COORD_BITS +: COORD_BITS];
        sq_b = q_z_r;
      end
      default: begin
        sq_a = rd_r[ID_W +: COORD_BITS];
        sq_b = q_x_r;
      end
    endcase
  end

  nps_sq_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_sq_unit (
    .clk  (clk),
    .a    (sq_a),
    .b    (sq_b),
    .sq_r (sq_r)
  );

  // Query latch, distance accumulation and running best.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_owner_r   <= in_owner;
      q_x_r       <= in_x;
      q_y_r       <= in_y;
      q_z_r       <= in_z;
      idx_r       <= '0;
      res_found_r <= (in_cmd == CMD_QUERY) && (in_cnt != '0);
      res_id_r    <= '0;
      res_full_r  <= (in_cmd == CMD_REGISTER) && in_full;
    end
    unique case (state_r)
      S_AX1: acc_r <= sq_r;
      S_AX2: acc_r <= acc_r + sq_r;
      S_CMP: begin
        if (better) begin
          best_r   <= cand_dist;
          res_id_r <= rd_r[ID_W-1:0];
        end
        idx_r <= idx_r + IDX_W'(1);
      end
      default: ;
    endcase
  end

  // Output register; it holds a result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= res_found_r;
      out_id_r    <= res_id_r;
      out_full_r  <= res_full_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - ID_W - 2){1'b0}}, out_full_r, out_id_r, out_found_r};

endmodule

@@ rtl/nps_checker.sv @@
// Port-level checks for the nearest point search, bound to the top level.
// Depends on nps_pkg and nearest_point_search_defines.svh.
`include "nearest_point_search_defines.svh"

module nps_port_checks import nps_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,   // entity_id[15:0], pos_x[31:16], pos_y[47:32], pos_z[63:48]
  input logic [IN_USER_W-1:0]  in_tuser,   // cmd[0], owner[1]
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata   // found[0], closest_id[16:1], table_full[17], zero[23:18]
);

  // No result is offered in the cycle after reset.
  `NPS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

  // A result waiting for the sink keeps its value.
  `NPS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // The block is busy in the cycle after it takes an item.
  `NPS_ASSERT(a_busy_after_transfer, in_tvalid && in_tready |=> !in_tready, "input ready right after a transfer")

  // A result never reports both a found point and a dropped registration.
  `NPS_ASSERT(a_flags_exclusive, out_tvalid |-> !(out_tdata[0] && out_tdata[17]), "found and table_full both set")

  // A result without a found point carries a zero identifier.
  `NPS_ASSERT(a_empty_id_zero, out_tvalid && !out_tdata[0] |-> out_tdata[16:1] == '0, "identifier set without a found point")

endmodule

bind nearest_point_search nps_port_checks u_nps_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
